/* sv/obb_frustum_cull_test_defines.svh */
// Assertion macros used by the checker file.
`ifndef OBB_FRUSTUM_CULL_TEST_DEFINES_SVH
`define OBB_FRUSTUM_CULL_TEST_DEFINES_SVH

// Clocked property, masked while reset is asserted.
`define OFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ofc assertion failed");

// Clocked property, checked during reset as well.
`define OFC_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ofc assertion failed");

`endif

/* sv/ofc_pkg.sv */
package ofc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int PLANE_W    = 64;
  localparam int ADDR_W     = 6;
  localparam int IDX_W      = 3;

  localparam logic [1:0] CLASS_INSIDE   = 2'd0;
  localparam logic [1:0] CLASS_SPANNING = 2'd1;
  localparam logic [1:0] CLASS_OUTSIDE  = 2'd2;

  typedef logic signed [15:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  typedef struct packed {
    vec3_t c;
    vec3_t h0;
    vec3_t h1;
    vec3_t h2;
  } box_t;

  // outside: some plane so far rejects the box; all_in: every plane so far accepts it
  typedef struct packed {
    logic outside;
    logic all_in;
  } flags_t;

endpackage

/* sv/ofc_cell.sv */
module ofc_cell
  import ofc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [PLANE_W-1:0] plane,
  input  logic               valid_in,
  input  box_t               box_in,
  input  flags_t             flags_in,
  output logic               valid_out,
  output box_t               box_out,
  output flags_t             flags_out
);

  coord_t             nrm [3];
  coord_t             vc  [4][3];
  logic signed [29:0] d_sc;

  // stage 1: products
  logic               v1_r;
  box_t               box1_r;
  flags_t             flg1_r;
  logic signed [31:0] prod_r   [4][3];
  logic signed [31:0] prod_nxt [4][3];

  // stage 2: dot products
  logic               v2_r;
  box_t               box2_r;
  flags_t             flg2_r;
  logic signed [33:0] dot_r   [4];
  logic signed [33:0] dot_nxt [4];

  // stage 3: radius and center distance
  logic               v3_r;
  box_t               box3_r;
  flags_t             flg3_r;
  logic        [35:0] rad_r;
  logic        [35:0] rad_nxt;
  logic signed [34:0] dist_r;
  logic signed [34:0] dist_nxt;
  logic        [33:0] mag [3];

  // stage 4: plane verdict folded into flags
  logic               v4_r;
  box_t               box4_r;
  flags_t             flg4_r;
  flags_t             flg4_nxt;
  logic signed [37:0] dist_w;
  logic signed [37:0] rad_w;

  assign nrm[0] = plane[63:48];
  assign nrm[1] = plane[47:32];
  assign nrm[2] = plane[31:16];
  assign d_sc   = {plane[15:0], 14'b0};

  always_comb begin
    vc[0][0] = box_in.c.x;  vc[0][1] = box_in.c.y;  vc[0][2] = box_in.c.z;
    vc[1][0] = box_in.h0.x; vc[1][1] = box_in.h0.y; vc[1][2] = box_in.h0.z;
    vc[2][0] = box_in.h1.x; vc[2][1] = box_in.h1.y; vc[2][2] = box_in.h1.z;
    vc[3][0] = box_in.h2.x; vc[3][1] = box_in.h2.y; vc[3][2] = box_in.h2.z;
    for (int v = 0; v < 4; v++) begin
      for (int k = 0; k < 3; k++) begin
        prod_nxt[v][k] = 32'(nrm[k]) * 32'(vc[v][k]);
      end
    end
  end

  always_comb begin
    for (int v = 0; v < 4; v++) begin
      dot_nxt[v] = 34'(prod_r[v][0]) + 34'(prod_r[v][1]) + 34'(prod_r[v][2]);
    end
  end

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      mag[v] = dot_r[v+1][33] ? 34'(-dot_r[v+1]) : 34'(dot_r[v+1]);
    end
    rad_nxt  = 36'(mag[0]) + 36'(mag[1]) + 36'(mag[2]);
    dist_nxt = 35'(dot_r[0]) + 35'(d_sc);
  end

  always_comb begin
    dist_w           = 38'(dist_r);
    rad_w            = $signed(38'(rad_r));
    flg4_nxt.outside = flg3_r.outside | (dist_w < -rad_w);
    flg4_nxt.all_in  = flg3_r.all_in & (dist_w > rad_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      box1_r <= box_in;
      flg1_r <= flags_in;
      prod_r <= prod_nxt;
      box2_r <= box1_r;
      flg2_r <= flg1_r;
      dot_r  <= dot_nxt;
      box3_r <= box2_r;
      flg3_r <= flg2_r;
      rad_r  <= rad_nxt;
      dist_r <= dist_nxt;
      box4_r <= box3_r;
      flg4_r <= flg4_nxt;
    end
  end

  assign valid_out = v4_r;
  assign box_out   = box4_r;
  assign flags_out = flg4_r;

endmodule

/* sv/obb_frustum_cull_test.sv */
// Channel   Handshake            Payload
// in        in_valid / in_stall  in_center_*, in_half0_*, in_half1_*, in_half2_*
// out       out_valid/ out_stall out_cull_class
// cfg       psel/penable/pready  paddr, pwdata, prdata (64-bit planes at 8*i)
//
// One box per cycle while the output is not stalled; six plane cells of four stages each
// (multiply, dot sum, radius and distance, compare) plus the output register.
// Synchronous active-low reset clears the valid bits; the plane registers reset to zero.
// A stalled output freezes the whole cell chain and raises in_stall.
module obb_frustum_cull_test
  import ofc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  coord_t              in_center_x,
  input  coord_t              in_center_y,
  input  coord_t              in_center_z,
  input  coord_t              in_half0_x,
  input  coord_t              in_half0_y,
  input  coord_t              in_half0_z,
  input  coord_t              in_half1_x,
  input  coord_t              in_half1_y,
  input  coord_t              in_half1_z,
  input  coord_t              in_half2_x,
  input  coord_t              in_half2_y,
  input  coord_t              in_half2_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_cull_class,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [PLANE_W-1:0]  pwdata,
  output logic [PLANE_W-1:0]  prdata,
  output logic                pready
);

  logic [PLANE_W-1:0] plane_r [NUM_PLANES];
  logic [IDX_W-1:0]   cfg_idx;
  logic               cfg_hit;

  logic   en;
  logic   valid_c [NUM_PLANES+1];
  box_t   box_c   [NUM_PLANES+1];
  flags_t flags_c [NUM_PLANES+1];

  logic       out_valid_r;
  logic [1:0] out_class_r;
  logic [1:0] out_class_nxt;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:ADDR_W-IDX_W];
  assign cfg_hit = cfg_idx < IDX_W'(NUM_PLANES);
  assign prdata  = cfg_hit ? plane_r[cfg_idx] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        plane_r[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      plane_r[cfg_idx] <= pwdata;
    end
  end

  // hold the chain while a result waits
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  assign valid_c[0]         = in_valid;
  assign box_c[0].c         = '{x: in_center_x, y: in_center_y, z: in_center_z};
  assign box_c[0].h0        = '{x: in_half0_x, y: in_half0_y, z: in_half0_z};
  assign box_c[0].h1        = '{x: in_half1_x, y: in_half1_y, z: in_half1_z};
  assign box_c[0].h2        = '{x: in_half2_x, y: in_half2_y, z: in_half2_z};
  assign flags_c[0].outside = 1'b0;
  assign flags_c[0].all_in  = 1'b1;

  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
    ofc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .plane     (plane_r[g]),
      .valid_in  (valid_c[g]),
      .box_in    (box_c[g]),
      .flags_in  (flags_c[g]),
      .valid_out (valid_c[g+1]),
      .box_out   (box_c[g+1]),
      .flags_out (flags_c[g+1])
    );
  end

  always_comb begin
    if (flags_c[NUM_PLANES].outside) begin
      out_class_nxt = CLASS_OUTSIDE;
    end else if (flags_c[NUM_PLANES].all_in) begin
      out_class_nxt = CLASS_INSIDE;
    end else begin
      out_class_nxt = CLASS_SPANNING;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid_c[NUM_PLANES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_class_r <= out_class_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cull_class = out_class_r;

endmodule

/* sv/ofc_checker.sv */
`include "obb_frustum_cull_test_defines.svh"

module ofc_checker
  import ofc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_cull_class,
  input logic       pready
);

  `OFC_ASSERT_ANY(a_out_idle_after_reset, !rst_n |=> !out_valid)
  `OFC_ASSERT(a_stall_only_when_full, in_stall |-> (out_valid && out_stall))
  `OFC_ASSERT(a_out_held, (out_valid && out_stall) |=> (out_valid && $stable(out_cull_class)))
  `OFC_ASSERT(a_class_legal, out_valid |-> (out_cull_class <= CLASS_OUTSIDE))
  `OFC_ASSERT(a_no_wait_states, pready)

endmodule

bind obb_frustum_cull_test ofc_checker u_ofc_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import ofc_pkg::*;

  typedef enum int {
    PLANE_LEFT   = 0,
    PLANE_RIGHT  = 1,
    PLANE_TOP    = 2,
    PLANE_BOTTOM = 3,
    PLANE_NEAR   = 4,
    PLANE_FAR    = 5
  } plane_idx_t;

  localparam int PLANE_BAD_LO = NUM_PLANES;
  localparam int PLANE_BAD_HI = NUM_PLANES + 1;
  localparam int Q14_ONE      = 16384;
  localparam int HALF_ROOM    = 2560;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 50;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  coord_t             in_center_x = '0;
  coord_t             in_center_y = '0;
  coord_t             in_center_z = '0;
  coord_t             in_half0_x = '0;
  coord_t             in_half0_y = '0;
  coord_t             in_half0_z = '0;
  coord_t             in_half1_x = '0;
  coord_t             in_half1_y = '0;
  coord_t             in_half1_z = '0;
  coord_t             in_half2_x = '0;
  coord_t             in_half2_y = '0;
  coord_t             in_half2_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_cull_class;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [PLANE_W-1:0] pwdata = '0;
  logic [PLANE_W-1:0] prdata;
  logic               pready;

  logic [PLANE_W-1:0] plane_model [NUM_PLANES];
  logic [1:0]         pending_class [$];
  int                 error_count = 0;
  int                 cycle_count = 0;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;

  obb_frustum_cull_test uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_center_z    (in_center_z),
    .in_half0_x     (in_half0_x),
    .in_half0_y     (in_half0_y),
    .in_half0_z     (in_half0_z),
    .in_half1_x     (in_half1_x),
    .in_half1_y     (in_half1_y),
    .in_half1_z     (in_half1_z),
    .in_half2_x     (in_half2_x),
    .in_half2_y     (in_half2_y),
    .in_half2_z     (in_half2_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cull_class (out_cull_class),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("obb_frustum_cull_test regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < MAX_REPORTS)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk) begin
    logic [1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_class.size() == 0) begin
        report_mismatch("result with no pending box", out_cull_class, 0);
      end else begin
        want = pending_class.pop_front();
        if (out_cull_class !== want)
          report_mismatch("cull_class", out_cull_class, want);
      end
    end
  end

  function automatic longint dot_q(longint nx, longint ny, longint nz, vec3_t v);
    return nx * longint'(v.x) + ny * longint'(v.y) + nz * longint'(v.z);
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [1:0] classify_box(box_t b);
    logic [63:0] w;
    longint nx, ny, nz, dd, rad, sdist;
    int n_in;
    bit rejected;
    n_in = 0;
    rejected = 1'b0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      w = plane_model[p];
      nx = longint'($signed(w[63:48]));
      ny = longint'($signed(w[47:32]));
      nz = longint'($signed(w[31:16]));
      dd = longint'($signed(w[15:0]));
      rad = mag(dot_q(nx, ny, nz, b.h0)) + mag(dot_q(nx, ny, nz, b.h1))
          + mag(dot_q(nx, ny, nz, b.h2));
      sdist = dot_q(nx, ny, nz, b.c) + dd * 16384;
      if (sdist < -rad)
        rejected = 1'b1;
      else if (sdist > rad)
        n_in++;
    end
    if (rejected)
      return CLASS_OUTSIDE;
    else if (n_in == NUM_PLANES)
      return CLASS_INSIDE;
    else
      return CLASS_SPANNING;
  endfunction

  function automatic logic [63:0] pack_plane(int a, int b, int c, int d);
    return {a[15:0], b[15:0], c[15:0], d[15:0]};
  endfunction

  function automatic vec3_t v3(int x, int y, int z);
    return '{coord_t'(x), coord_t'(y), coord_t'(z)};
  endfunction

  function automatic int rnd_signed(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic vec3_t rnd_vec(int m);
    return v3(rnd_signed(m), rnd_signed(m), rnd_signed(m));
  endfunction

  function automatic box_t rnd_box();
    int kind;
    kind = $urandom_range(0, 3);
    if (kind <= 1)
      return '{rnd_vec(1024), rnd_vec(256), rnd_vec(256), rnd_vec(256)};
    else if (kind == 2)
      return '{rnd_vec(12000), rnd_vec(3000), rnd_vec(3000), rnd_vec(3000)};
    else
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic send_box(box_t b);
    int gap;
    gap = 0;
    pending_class.push_back(classify_box(b));
    while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_center_x <= b.c.x;
    in_center_y <= b.c.y;
    in_center_z <= b.c.z;
    in_half0_x  <= b.h0.x;
    in_half0_y  <= b.h0.y;
    in_half0_z  <= b.h0.z;
    in_half1_x  <= b.h1.x;
    in_half1_y  <= b.h1.y;
    in_half1_z  <= b.h1.z;
    in_half2_x  <= b.h2.x;
    in_half2_y  <= b.h2.y;
    in_half2_z  <= b.h2.z;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_class.size() != 0)
      @(posedge clk);
  endtask

  task automatic cfg_access(bit wr, int idx, logic [63:0] val, output logic [63:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(idx * 8);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_plane(int idx, logic [63:0] val);
    logic [63:0] rd;
    cfg_access(1'b1, idx, val, rd);
    if (idx < NUM_PLANES)
      plane_model[idx] = val;
  endtask

  task automatic check_planes();
    logic [63:0] rd;
    for (int i = 0; i < NUM_PLANES; i++) begin
      cfg_access(1'b0, i, '0, rd);
      if (rd !== plane_model[i])
        report_mismatch("plane readback", rd, plane_model[i]);
    end
  endtask

  task automatic write_all_planes(logic [63:0] val);
    for (int i = 0; i < NUM_PLANES; i++)
      write_plane(i, val);
  endtask

  task automatic test_reset_state();
    check_planes();
    send_box('0);
    send_box('{v3(32767, -32768, 100), v3(1, 0, 0), v3(0, -1, 0), v3(0, 0, 32767)});
    wait_idle();
  endtask

  task automatic test_box_frustum();
    wait_idle();
    write_plane(PLANE_LEFT,   pack_plane(Q14_ONE, 0, 0, HALF_ROOM));
    write_plane(PLANE_RIGHT,  pack_plane(-Q14_ONE, 0, 0, HALF_ROOM));
    write_plane(PLANE_TOP,    pack_plane(0, -Q14_ONE, 0, HALF_ROOM));
    write_plane(PLANE_BOTTOM, pack_plane(0, Q14_ONE, 0, HALF_ROOM));
    write_plane(PLANE_NEAR,   pack_plane(0, 0, Q14_ONE, HALF_ROOM));
    write_plane(PLANE_FAR,    pack_plane(0, 0, -Q14_ONE, HALF_ROOM));
    check_planes();
    send_box('{v3(0, 0, 0), v3(256, 0, 0), v3(0, 256, 0), v3(0, 0, 256)});
    send_box('{v3(-5120, 0, 0), v3(256, 0, 0), v3(0, 256, 0), v3(0, 0, 256)});
    send_box('{v3(0, 2560, 0), v3(256, 0, 0), v3(0, 256, 0), v3(0, 0, 256)});
    // distance equals radius on the left plane
    send_box('{v3(-HALF_ROOM + 256, 0, 0), v3(256, 0, 0), v3(0, 0, 0), v3(0, 0, 0)});
    // distance equals minus the radius on the left plane
    send_box('{v3(-HALF_ROOM - 256, 0, 0), v3(256, 0, 0), v3(0, 0, 0), v3(0, 0, 0)});
    wait_idle();
  endtask

  task automatic test_unnormalized_planes();
    write_plane(PLANE_LEFT,  pack_plane(24576, -8192, 4096, 1000));
    write_plane(PLANE_RIGHT, pack_plane(-24576, 30000, 0, 4000));
    write_plane(PLANE_NEAR,  pack_plane(32767, 32767, 32767, 32767));
    check_planes();
    send_box('{v3(0, 0, 0), v3(64, 0, 0), v3(0, 64, 0), v3(0, 0, 64)});
    send_box('{v3(-1000, 500, 200), v3(128, -64, 0), v3(0, 32, 16), v3(8, 8, 8)});
    send_box('{v3(9000, -9000, 0), v3(2000, 0, 0), v3(0, 2000, 0), v3(0, 0, 2000)});
    wait_idle();
  endtask

  task automatic test_bad_index();
    write_plane(PLANE_BAD_LO, '1);
    write_plane(PLANE_BAD_HI, '1);
    check_planes();
    send_box('{v3(0, 0, 0), v3(64, 0, 0), v3(0, 64, 0), v3(0, 0, 64)});
    send_box('{v3(-1000, 500, 200), v3(128, -64, 0), v3(0, 32, 16), v3(8, 8, 8)});
    wait_idle();
  endtask

  task automatic test_field_extremes();
    logic [63:0] settings [3];
    settings[0] = 64'h7fff_7fff_7fff_7fff;
    settings[1] = 64'h8000_8000_8000_8000;
    settings[2] = '1;
    foreach (settings[s]) begin
      write_all_planes(settings[s]);
      check_planes();
      send_box({12{16'h7fff}});
      send_box({12{16'h8000}});
      wait_idle();
    end
  endtask

  task automatic test_random_stream(int idle, int stall, bit wide_planes, int items);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int s = 0; s < 2; s++) begin
      wait_idle();
      for (int i = 0; i < NUM_PLANES; i++) begin
        if (wide_planes && s == 1)
          write_plane(i, {$urandom, $urandom});
        else
          write_plane(i, pack_plane(rnd_signed(Q14_ONE), rnd_signed(Q14_ONE),
                                    rnd_signed(Q14_ONE), $urandom_range(768, 12000)));
      end
      for (int n = 0; n < items / 2; n++)
        send_box(rnd_box());
    end
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < NUM_PLANES; i++)
      plane_model[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_box_frustum();
    test_unnormalized_planes();
    test_bad_index();
    test_field_extremes();
    test_random_stream(0, 0, 1'b0, 170);
    test_random_stream(60, 0, 1'b1, 170);
    test_random_stream(0, 60, 1'b0, 170);
    test_random_stream(34, 34, 1'b1, 170);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("obb_frustum_cull_test regression: pass");
    else
      $display("obb_frustum_cull_test regression: fail");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/ofc_pkg.sv
sv/ofc_cell.sv
sv/obb_frustum_cull_test.sv
sv/ofc_checker.sv
bench/tb_top.sv
